// File: rtl/percent_feed_monitor_core_assert.svh
// assertion macros shared by the percent feed monitor rtl
// expects a clock i_clk and an active-low reset i_rst_n in the including module
`ifndef PERCENT_FEED_MONITOR_CORE_ASSERT_SVH
`define PERCENT_FEED_MONITOR_CORE_ASSERT_SVH

// same-cycle implication
`define PFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pfm_pkg.sv
// shared types and constants for the percent feed monitor
// no dependencies
`default_nettype none

package pfm_pkg;

    localparam int LINE_MAX_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STALE_MS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMBER_AT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_AT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PANIC_AT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EASE_SHIFT = 3'd4;

    localparam logic [31:0] STALE_MS_RST   = 32'd12000;
    localparam logic [6:0]  AMBER_AT_RST   = 7'd50;
    localparam logic [6:0]  RED_AT_RST     = 7'd80;
    localparam logic [6:0]  PANIC_AT_RST   = 7'd95;
    localparam logic [2:0]  EASE_SHIFT_RST = 3'd3;

    localparam logic [9:0]  PCT_MAX = 10'd100;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_WAIT  = 2'd0,
        MODE_LIVE  = 2'd1,
        MODE_STALE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // verdict on the line collected so far
    typedef struct packed {
        logic       ok;
        logic [6:0] first_value;
        logic [6:0] second_value;
    } t_line_result;

endpackage

`default_nettype wire

// File: rtl/percent_feed_monitor_core.sv
// top level of the percent feed monitor: input register, state update, result register
// depends on pfm_pkg, pfm_line_parser and percent_feed_monitor_core_assert.svh
`default_nettype none

// The block takes one item (serial byte or frame tick) per clock cycle and returns
// exactly one result per item: the item is held in the input register, where the line
// parser and the easing, mode and level logic work, and its result is then held in the
// result register. Input and result registers are separate, so a new item is
// taken every cycle while the result register drains; when the result side stalls,
// one item waits in the input register and the input side drops ready.

`include "percent_feed_monitor_core_assert.svh"

module percent_feed_monitor_core import pfm_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_cmd,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic [31:0]           i_now_ms,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_mode,
    output logic [6:0]                 o_session_shown,
    output logic [6:0]                 o_week_shown,
    output logic [1:0]                 o_session_level,
    output logic [1:0]                 o_week_level,
    output logic [1:0]                 o_face_level,
    output logic                       o_redraw,
    output logic                       o_line_accepted,
    output logic                       o_line_rejected
);

    // configuration
    logic [31:0] r_stale_ms;
    logic [6:0]  r_amber_at, r_red_at, r_panic_at;
    logic [2:0]  r_ease_shift;

    // input register
    logic        r_in_valid, r_in_cmd;
    logic [7:0]  r_in_byte;
    logic [31:0] r_in_now;

    // monitor state
    logic [6:0]  r_sess_tgt, r_week_tgt, r_sess_now, r_week_now;
    logic        r_have_data;
    logic [31:0] r_last_ms;
    t_mode       r_prev_mode;

    logic [6:0]  n_sess_tgt, n_week_tgt, n_sess_now, n_week_now;
    logic        n_have_data;
    logic [31:0] n_last_ms;
    t_mode       n_prev_mode;

    // result register
    logic        r_out_valid;
    t_mode       r_out_mode;
    logic [6:0]  r_out_sess, r_out_week;
    logic [1:0]  r_out_sess_lvl, r_out_week_lvl, r_out_face;
    logic        r_out_redraw, r_out_acc, r_out_rej;

    logic         c_step, c_is_byte, c_is_tick, c_acc, c_rej, c_redraw;
    t_mode        c_mode;
    logic [31:0]  c_elapsed;
    logic [6:0]   c_max;
    logic [1:0]   c_face;
    t_line_result c_line;

    function automatic logic [6:0] ease_step(input logic [6:0] cur, input logic [6:0] tgt,
                                             input logic [2:0] sh);
        logic [7:0] add;
        logic [7:0] diff;
        logic [7:0] stp;
        add  = (8'd1 << sh) - 8'd1;
        diff = 8'd0;
        stp  = 8'd0;
        if (cur < tgt) begin
            diff = 8'(tgt) - 8'(cur);
            stp  = (diff + add) >> sh;
            return cur + stp[6:0];
        end else if (cur > tgt) begin
            diff = 8'(cur) - 8'(tgt);
            stp  = (diff + add) >> sh;
            return cur - stp[6:0];
        end
        return cur;
    endfunction

    function automatic logic [1:0] colour_of(input logic [6:0] p, input logic [6:0] amber,
                                             input logic [6:0] red);
        priority if (p < amber) return 2'd0;
        else if (p < red)       return 2'd1;
        else                    return 2'd2;
    endfunction

    function automatic logic [1:0] face_of(input logic [6:0] p, input logic [6:0] amber,
                                           input logic [6:0] red, input logic [6:0] panic);
        priority if (p < amber) return 2'd0;
        else if (p < red)       return 2'd1;
        else if (p < panic)     return 2'd2;
        else                    return 2'd3;
    endfunction

    assign c_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || c_step;
    assign c_is_byte  = (r_in_cmd == CMD_BYTE);
    assign c_is_tick  = (r_in_cmd == CMD_TICK);

    pfm_line_parser #(
        .LINE_MAX (LINE_MAX)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (c_step && c_is_byte),
        .i_rx_byte (r_in_byte),
        .o_line    (c_line)
    );

    always_comb begin
        n_sess_tgt  = r_sess_tgt;
        n_week_tgt  = r_week_tgt;
        n_sess_now  = r_sess_now;
        n_week_now  = r_week_now;
        n_have_data = r_have_data;
        n_last_ms   = r_last_ms;
        n_prev_mode = r_prev_mode;
        c_acc       = 1'b0;
        c_rej       = 1'b0;
        c_redraw    = 1'b0;

        if (c_is_byte && r_in_byte == CH_LF) begin
            if (c_line.ok) begin
                n_sess_tgt  = c_line.first_value;
                n_week_tgt  = c_line.second_value;
                n_have_data = 1'b1;
                n_last_ms   = r_in_now;
                c_acc       = 1'b1;
            end else begin
                c_rej = 1'b1;
            end
        end

        // mode is taken after any target update of this byte
        c_elapsed = r_in_now - n_last_ms;
        if (!n_have_data)                c_mode = MODE_WAIT;
        else if (c_elapsed > r_stale_ms) c_mode = MODE_STALE;
        else                             c_mode = MODE_LIVE;

        if (c_is_tick) begin
            if (c_mode == MODE_LIVE) begin
                n_sess_now = ease_step(r_sess_now, r_sess_tgt, r_ease_shift);
                n_week_now = ease_step(r_week_now, r_week_tgt, r_ease_shift);
                c_redraw   = (n_sess_now != r_sess_now) || (n_week_now != r_week_now) ||
                             (r_prev_mode != MODE_LIVE);
            end else begin
                c_redraw = (c_mode != r_prev_mode);
            end
            n_prev_mode = c_mode;
        end

        c_max  = (n_sess_now > n_week_now) ? n_sess_now : n_week_now;
        c_face = (c_mode == MODE_LIVE) ?
                 face_of(c_max, r_amber_at, r_red_at, r_panic_at) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_ms   <= STALE_MS_RST;
            r_amber_at   <= AMBER_AT_RST;
            r_red_at     <= RED_AT_RST;
            r_panic_at   <= PANIC_AT_RST;
            r_ease_shift <= EASE_SHIFT_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sess_tgt   <= '0;
            r_week_tgt   <= '0;
            r_sess_now   <= '0;
            r_week_now   <= '0;
            r_have_data  <= 1'b0;
            r_last_ms    <= '0;
            r_prev_mode  <= MODE_NONE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_STALE_MS:   r_stale_ms   <= i_cfg_data;
                    REG_AMBER_AT:   r_amber_at   <= i_cfg_data[6:0];
                    REG_RED_AT:     r_red_at     <= i_cfg_data[6:0];
                    REG_PANIC_AT:   r_panic_at   <= i_cfg_data[6:0];
                    REG_EASE_SHIFT: r_ease_shift <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (o_in_ready) r_in_valid <= i_in_valid;

            if (c_step) begin
                r_out_valid <= 1'b1;
                r_sess_tgt  <= n_sess_tgt;
                r_week_tgt  <= n_week_tgt;
                r_sess_now  <= n_sess_now;
                r_week_now  <= n_week_now;
                r_have_data <= n_have_data;
                r_last_ms   <= n_last_ms;
                r_prev_mode <= n_prev_mode;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_rx_byte;
            r_in_now  <= i_now_ms;
        end
        if (c_step) begin
            r_out_mode     <= c_mode;
            r_out_sess     <= n_sess_now;
            r_out_week     <= n_week_now;
            r_out_sess_lvl <= colour_of(n_sess_now, r_amber_at, r_red_at);
            r_out_week_lvl <= colour_of(n_week_now, r_amber_at, r_red_at);
            r_out_face     <= c_face;
            r_out_redraw   <= c_redraw;
            r_out_acc      <= c_acc;
            r_out_rej      <= c_rej;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mode          = r_out_mode;
    assign o_session_shown = r_out_sess;
    assign o_week_shown    = r_out_week;
    assign o_session_level = r_out_sess_lvl;
    assign o_week_level    = r_out_week_lvl;
    assign o_face_level    = r_out_face;
    assign o_redraw        = r_out_redraw;
    assign o_line_accepted = r_out_acc;
    assign o_line_rejected = r_out_rej;

    `PFM_ASSERT_NOW(a_face_only_live, o_out_valid && o_face_level != 2'd0,
        o_mode == MODE_LIVE, "face level set outside live mode")
    `PFM_ASSERT_NOW(a_line_flags_excl, o_out_valid,
        !(o_line_accepted && o_line_rejected) && !(o_redraw && o_line_accepted)
        && !(o_redraw && o_line_rejected), "line flags and redraw overlap")
    `PFM_ASSERT_NEXT(a_stalled_item_kept, r_in_valid && !c_step,
        r_in_valid && $stable(r_in_now) && $stable(r_in_byte), "waiting item lost")
    `PFM_ASSERT_NEXT(a_data_stays, r_have_data, r_have_data, "data present flag dropped")
    `PFM_ASSERT_NOW(a_shown_in_range, 1'b1,
        r_sess_now <= PCT_MAX[6:0] && r_week_now <= PCT_MAX[6:0], "shown value above 100")

endmodule

`default_nettype wire

// File: rtl/pfm_line_parser.sv
// line parser: collects "a,b" text lines byte by byte and judges them
// depends on pfm_pkg
`default_nettype none

module pfm_line_parser import pfm_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_byte_en,
    input  wire logic [7:0]   i_rx_byte,
    output t_line_result      o_line
);

    localparam int CNT_W = $clog2(LINE_MAX + 1);

    typedef enum logic [2:0] {
        PH_LEAD1  = 3'd0,
        PH_DIG1   = 3'd1,
        PH_TRAIL1 = 3'd2,
        PH_LEAD2  = 3'd3,
        PH_DIG2   = 3'd4,
        PH_TRAIL2 = 3'd5
    } t_phase;

    logic [CNT_W-1:0] r_chars, n_chars;
    t_phase           r_phase, n_phase;
    logic [9:0]       r_val1, n_val1, r_val2, n_val2;
    logic [2:0]       r_cnt1, n_cnt1, r_cnt2, n_cnt2;
    logic             r_bad, n_bad;

    logic             c_dig, c_blank, c_comma;
    logic [3:0]       c_d;

    assign c_dig   = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign c_blank = (i_rx_byte == CH_SPACE) || (i_rx_byte == CH_TAB) ||
                     (i_rx_byte == CH_VT) || (i_rx_byte == CH_FF);
    assign c_comma = (i_rx_byte == CH_COMMA);
    assign c_d     = i_rx_byte[3:0];

    always_comb begin
        n_chars = r_chars;
        n_phase = r_phase;
        n_val1  = r_val1;
        n_val2  = r_val2;
        n_cnt1  = r_cnt1;
        n_cnt2  = r_cnt2;
        n_bad   = r_bad;
        if (i_rx_byte == CH_LF) begin
            n_chars = '0;
            n_phase = PH_LEAD1;
            n_val1  = '0;
            n_val2  = '0;
            n_cnt1  = '0;
            n_cnt2  = '0;
            n_bad   = 1'b0;
        end else if (i_rx_byte != CH_CR && r_chars < CNT_W'(LINE_MAX)) begin
            n_chars = r_chars + CNT_W'(1);
            if (!r_bad) begin
                unique case (r_phase)
                    PH_LEAD1, PH_DIG1: begin
                        if (c_dig) begin
                            // fourth digit marks the line bad
                            if (r_cnt1 < 3'd3) begin
                                n_val1 = (r_val1 << 3) + (r_val1 << 1) + 10'(c_d);
                                n_cnt1 = r_cnt1 + 3'd1;
                            end else begin
                                n_cnt1 = 3'd4;
                                n_bad  = 1'b1;
                            end
                            n_phase = PH_DIG1;
                        end else if (c_blank) begin
                            if (r_phase == PH_DIG1) n_phase = PH_TRAIL1;
                        end else if (c_comma && r_phase == PH_DIG1) begin
                            n_phase = PH_LEAD2;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    PH_TRAIL1: begin
                        if (c_comma) n_phase = PH_LEAD2;
                        else if (!c_blank) n_bad = 1'b1;
                    end
                    PH_LEAD2, PH_DIG2: begin
                        if (c_dig) begin
                            if (r_cnt2 < 3'd3) begin
                                n_val2 = (r_val2 << 3) + (r_val2 << 1) + 10'(c_d);
                                n_cnt2 = r_cnt2 + 3'd1;
                            end else begin
                                n_cnt2 = 3'd4;
                                n_bad  = 1'b1;
                            end
                            n_phase = PH_DIG2;
                        end else if (c_blank) begin
                            if (r_phase == PH_DIG2) n_phase = PH_TRAIL2;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    default: begin
                        if (!c_blank) n_bad = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= '0;
            r_phase <= PH_LEAD1;
            r_val1  <= '0;
            r_val2  <= '0;
            r_cnt1  <= '0;
            r_cnt2  <= '0;
            r_bad   <= 1'b0;
        end else if (i_byte_en) begin
            r_chars <= n_chars;
            r_phase <= n_phase;
            r_val1  <= n_val1;
            r_val2  <= n_val2;
            r_cnt1  <= n_cnt1;
            r_cnt2  <= n_cnt2;
            r_bad   <= n_bad;
        end
    end

    assign o_line.ok = !r_bad && (r_phase == PH_DIG2 || r_phase == PH_TRAIL2) &&
                       r_cnt1 >= 3'd1 && r_cnt1 <= 3'd3 &&
                       r_cnt2 >= 3'd1 && r_cnt2 <= 3'd3 &&
                       r_val1 <= PCT_MAX && r_val2 <= PCT_MAX;
    assign o_line.first_value  = r_val1[6:0];
    assign o_line.second_value = r_val2[6:0];

endmodule

`default_nettype wire

// File: tb/tb_percent_feed_monitor_core.sv
// testbench for percent_feed_monitor_core: serial line parsing, mode, easing and levels
// depends on pfm_pkg and the rtl top; a scoreboard class predicts one readout per transfer
`default_nettype none

module tb_percent_feed_monitor_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pfm_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 80;
    localparam int IDLE_PCT        = 31;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int SHOW_LIMIT      = 10;

    typedef enum logic [2:0] {
        FLD_LEAD1, FLD_DIG1, FLD_TRAIL1, FLD_LEAD2, FLD_DIG2, FLD_TRAIL2
    } t_field_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] session_shown;
        logic [6:0] week_shown;
        logic [1:0] session_level;
        logic [1:0] week_level;
        logic [1:0] face_level;
        logic       redraw;
        logic       accepted;
        logic       rejected;
    } t_readout;

    class t_feed_tracker;
        bit [31:0]    stale_lim;
        bit [6:0]     amber_pct, red_pct, panic_pct;
        bit [2:0]     shift;
        int unsigned  kept;
        t_field_phase phase;
        bit [9:0]     val_a, val_b;
        bit [2:0]     dig_a, dig_b;
        bit           bad;
        bit [6:0]     tgt_a, tgt_b, shown_a, shown_b;
        bit           have_data;
        bit [31:0]    fresh_ms;
        t_mode        last_mode;
        t_readout     expected_readouts[$];
        int           mismatches;

        function new();
            stale_lim = STALE_MS_RST;
            amber_pct = AMBER_AT_RST;
            red_pct   = RED_AT_RST;
            panic_pct = PANIC_AT_RST;
            shift     = EASE_SHIFT_RST;
            clear_line();
            tgt_a = '0; tgt_b = '0; shown_a = '0; shown_b = '0;
            have_data = 1'b0;
            fresh_ms  = '0;
            last_mode = MODE_NONE;
            mismatches = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STALE_MS:   stale_lim = data;
                REG_AMBER_AT:   amber_pct = data[6:0];
                REG_RED_AT:     red_pct   = data[6:0];
                REG_PANIC_AT:   panic_pct = data[6:0];
                REG_EASE_SHIFT: shift     = data[2:0];
                default: ;
            endcase
        endfunction

        function void clear_line();
            kept = 0;
            phase = FLD_LEAD1;
            val_a = '0; val_b = '0; dig_a = '0; dig_b = '0;
            bad = 1'b0;
        endfunction

        function void push_digit(inout bit [9:0] v, inout bit [2:0] n, input bit [7:0] c);
            if (n < 3) begin
                v = 10'(int'(v) * 10 + int'(c - CH_ZERO));
                n = n + 1;
            end else begin
                n = 4;
                bad = 1'b1;
            end
        endfunction

        function void take_char(bit [7:0] c);
            bit dig, blank, comma;
            dig   = (c >= CH_ZERO) && (c <= CH_NINE);
            blank = c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
            comma = (c == CH_COMMA);
            if (bad) return;
            case (phase)
                FLD_LEAD1: begin
                    if (dig) begin
                        push_digit(val_a, dig_a, c);
                        phase = FLD_DIG1;
                    end else if (!blank) begin
                        bad = 1'b1;
                    end
                end
                FLD_DIG1: begin
                    if (dig) push_digit(val_a, dig_a, c);
                    else if (blank) phase = FLD_TRAIL1;
                    else if (comma) phase = FLD_LEAD2;
                    else bad = 1'b1;
                end
                FLD_TRAIL1: begin
                    if (comma) phase = FLD_LEAD2;
                    else if (!blank) bad = 1'b1;
                end
                FLD_LEAD2: begin
                    if (dig) begin
                        push_digit(val_b, dig_b, c);
                        phase = FLD_DIG2;
                    end else if (!blank) begin
                        bad = 1'b1;
                    end
                end
                FLD_DIG2: begin
                    if (dig) push_digit(val_b, dig_b, c);
                    else if (blank) phase = FLD_TRAIL2;
                    else bad = 1'b1;
                end
                default: begin
                    if (!blank) bad = 1'b1;
                end
            endcase
        endfunction

        // step is ceiling of the gap over 2^shift
        function bit [6:0] ease_toward(bit [6:0] cur, bit [6:0] tgt);
            int add;
            add = (1 << shift) - 1;
            if (cur < tgt) return 7'(int'(cur) + ((int'(tgt) - int'(cur) + add) >> shift));
            if (cur > tgt) return 7'(int'(cur) - ((int'(cur) - int'(tgt) + add) >> shift));
            return cur;
        endfunction

        function bit [1:0] colour_of_pct(bit [6:0] p);
            if (p < amber_pct) return 2'd0;
            if (p < red_pct) return 2'd1;
            return 2'd2;
        endfunction

        function bit [1:0] face_of_pct(bit [6:0] p);
            if (p < amber_pct) return 2'd0;
            if (p < red_pct) return 2'd1;
            if (p < panic_pct) return 2'd2;
            return 2'd3;
        endfunction

        function t_mode mode_at(bit [31:0] now);
            bit [31:0] gap;
            gap = now - fresh_ms;
            if (!have_data) return MODE_WAIT;
            return (gap > stale_lim) ? MODE_STALE : MODE_LIVE;
        endfunction

        function void take_item(bit c_kind, bit [7:0] c, bit [31:0] now);
            t_readout r;
            t_mode    m;
            bit [6:0] ns, nw, top;
            bit       ok;
            r = '0;
            if (c_kind == CMD_BYTE) begin
                if (c == CH_LF) begin
                    ok = !bad && (phase >= FLD_DIG2) && (dig_a >= 1) && (dig_a <= 3) &&
                         (dig_b >= 1) && (dig_b <= 3) && (val_a <= PCT_MAX) &&
                         (val_b <= PCT_MAX);
                    if (ok) begin
                        tgt_a = val_a[6:0];
                        tgt_b = val_b[6:0];
                        have_data = 1'b1;
                        fresh_ms = now;
                        r.accepted = 1'b1;
                    end else begin
                        r.rejected = 1'b1;
                    end
                    clear_line();
                end else if (c != CH_CR && kept < LINE_MAX_DEF) begin
                    kept++;
                    take_char(c);
                end
                m = mode_at(now);
            end else begin
                m = mode_at(now);
                if (m == MODE_LIVE) begin
                    ns = ease_toward(shown_a, tgt_a);
                    nw = ease_toward(shown_b, tgt_b);
                    if (ns != shown_a || nw != shown_b || last_mode != MODE_LIVE)
                        r.redraw = 1'b1;
                    shown_a = ns;
                    shown_b = nw;
                end else if (m != last_mode) begin
                    r.redraw = 1'b1;
                end
                last_mode = m;
            end
            top = (shown_a > shown_b) ? shown_a : shown_b;
            r.mode          = m;
            r.session_shown = shown_a;
            r.week_shown    = shown_b;
            r.session_level = colour_of_pct(shown_a);
            r.week_level    = colour_of_pct(shown_b);
            r.face_level    = (m == MODE_LIVE) ? face_of_pct(top) : 2'd0;
            expected_readouts.push_back(r);
        endfunction

        function void check_result(t_readout got);
            t_readout want;
            if (expected_readouts.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected readout with nothing pending: %h", got);
                return;
            end
            want = expected_readouts.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("readout mismatch: expected mode=%0d shown=%0d/%0d lvl=%0d/%0d %s",
                             want.mode, want.session_shown, want.week_shown,
                             want.session_level, want.week_level, "");
                    $display("  expected face=%0d rd=%0b acc=%0b rej=%0b",
                             want.face_level, want.redraw, want.accepted, want.rejected);
                    $display("  got mode=%0d shown=%0d/%0d lvl=%0d/%0d",
                             got.mode, got.session_shown, got.week_shown,
                             got.session_level, got.week_level);
                    $display("  got face=%0d rd=%0b acc=%0b rej=%0b",
                             got.face_level, got.redraw, got.accepted, got.rejected);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = REG_STALE_MS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  cmd = CMD_BYTE;
    logic [7:0]            rx_byte = '0;
    logic [31:0]           now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            mode;
    logic [6:0]            session_shown, week_shown;
    logic [1:0]            session_level, week_level, face_level;
    logic                  redraw, line_accepted, line_rejected;

    bit            tx_idle_en = 1'b1;
    bit            rx_idle_en = 1'b1;
    bit            hold_req = 1'b0;
    bit            hold_done = 1'b0;
    int unsigned   cycle_count = 0;
    int unsigned   items_sent = 0;
    bit [31:0]     clock_ms = '0;
    bit [7:0]      line_buf[$];
    t_feed_tracker board;

    percent_feed_monitor_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_cmd           (cmd),
        .i_rx_byte       (rx_byte),
        .i_now_ms        (now_ms),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_mode          (mode),
        .o_session_shown (session_shown),
        .o_week_shown    (week_shown),
        .o_session_level (session_level),
        .o_week_level    (week_level),
        .o_face_level    (face_level),
        .o_redraw        (redraw),
        .o_line_accepted (line_accepted),
        .o_line_rejected (line_rejected)
    );

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    always begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
            out_ready = 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
        end
        out_ready = !(rx_idle_en && $urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_result({mode, session_shown, week_shown, session_level, week_level,
                                face_level, redraw, line_accepted, line_rejected});
    end

    function automatic bit [31:0] advance_clock();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) clock_ms = $urandom;
        else if (r < 8) clock_ms += $urandom_range(0, 40000);
        else if (r >= 45) clock_ms += $urandom_range(1, 25);
        return clock_ms;
    endfunction

    function automatic int pick_pct();
        if ($urandom_range(0, 9) < 3) return $urandom_range(0, 1) ? 100 : 0;
        return $urandom_range(0, 100);
    endfunction

    function automatic int digits_of(int v);
        return (v >= 100) ? 3 : ((v >= 10) ? 2 : 1);
    endfunction

    function automatic void push_blanks(int n);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0: line_buf.push_back(CH_SPACE);
                1: line_buf.push_back(CH_TAB);
                2: line_buf.push_back(CH_VT);
                3: line_buf.push_back(CH_FF);
                default: line_buf.push_back(CH_CR);
            endcase
        end
    endfunction

    // leading zeros pad the value out to ndig digits
    function automatic void push_number(int v, int ndig);
        int div;
        div = 1;
        repeat (ndig - 1) div *= 10;
        repeat (ndig) begin
            line_buf.push_back(8'(int'(CH_ZERO) + (v / div) % 10));
            div /= 10;
        end
    endfunction

    function automatic void push_pair();
        int a, b;
        a = pick_pct();
        b = pick_pct();
        push_blanks($urandom_range(0, 2));
        push_number(a, $urandom_range(digits_of(a), 3));
        push_blanks($urandom_range(0, 2));
        line_buf.push_back(CH_COMMA);
        push_blanks($urandom_range(0, 2));
        push_number(b, $urandom_range(digits_of(b), 3));
        push_blanks($urandom_range(0, 2));
    endfunction

    function automatic void build_broken_line();
        int v;
        case ($urandom_range(0, 7))
            0: begin
                // no comma between the fields
                v = pick_pct();
                push_blanks($urandom_range(0, 2));
                push_number(v, digits_of(v));
                push_blanks($urandom_range(0, 2));
                if ($urandom_range(0, 1)) push_number(pick_pct(), 1);
            end
            1: push_blanks($urandom_range(0, 3));
            2: begin
                push_pair();
                line_buf.push_back(CH_COMMA);
                push_number(pick_pct() % 10, 1);
            end
            3: begin
                if ($urandom_range(0, 1)) begin
                    push_blanks($urandom_range(0, 1));
                    line_buf.push_back(CH_COMMA);
                    push_number(pick_pct() % 10, 1);
                end else begin
                    push_number(pick_pct() % 10, 1);
                    line_buf.push_back(CH_COMMA);
                    push_blanks($urandom_range(0, 1));
                end
            end
            4: begin
                if ($urandom_range(0, 1)) begin
                    push_number(pick_pct(), $urandom_range(4, 5));
                    line_buf.push_back(CH_COMMA);
                    push_number(pick_pct() % 10, 1);
                end else begin
                    push_number(pick_pct() % 10, 1);
                    line_buf.push_back(CH_COMMA);
                    push_number(pick_pct(), 4);
                end
            end
            5: begin
                v = $urandom_range(101, 999);
                if ($urandom_range(0, 1)) begin
                    push_number(v, 3);
                    line_buf.push_back(CH_COMMA);
                    push_number(pick_pct() % 10, 1);
                end else begin
                    push_number(pick_pct() % 10, 1);
                    line_buf.push_back(CH_COMMA);
                    push_number(v, 3);
                end
            end
            6: begin
                push_pair();
                line_buf.insert($urandom_range(0, line_buf.size()), 8'($urandom_range(0, 255)));
            end
            default: begin
                // long line: either the tail may be dropped or the pair may be cut off
                if ($urandom_range(0, 1)) begin
                    push_pair();
                    repeat ($urandom_range(1, LINE_MAX_DEF)) line_buf.push_back(CH_SPACE);
                    line_buf.push_back(8'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(10, LINE_MAX_DEF)) line_buf.push_back(CH_SPACE);
                    push_pair();
                end
            end
        endcase
        line_buf.push_back(CH_LF);
    endfunction

    task automatic send_item(bit c_kind, bit [7:0] b, bit [31:0] t);
        @(negedge clk);
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd      = c_kind;
        rx_byte  = b;
        now_ms   = t;
        do @(posedge clk); while (!in_ready);
        board.take_item(c_kind, b, t);
        items_sent++;
    endtask

    task automatic send_text(string s, bit [31:0] t);
        for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i], t);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_item(CMD_BYTE, line_buf[i], advance_clock());
        line_buf.delete();
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)), advance_clock());
    endtask

    task automatic random_burst();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            push_pair();
            line_buf.push_back(CH_LF);
        end else if (r < 85) begin
            build_broken_line();
        end else begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        send_line();
        send_ticks($urandom_range(0, 3));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.expected_readouts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic setup_phase(int p);
        int unsigned a, r;
        case (p)
            1: begin
                set_reg(REG_STALE_MS, 32'd0);
                set_reg(REG_AMBER_AT, 32'd0);
                set_reg(REG_RED_AT, 32'd0);
                set_reg(REG_PANIC_AT, 32'd0);
                set_reg(REG_EASE_SHIFT, 32'd0);
            end
            2: begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
                set_reg(REG_STALE_MS, 32'hFFFF_FFFF);
                set_reg(REG_AMBER_AT, 32'd100);
                set_reg(REG_RED_AT, 32'd100);
                set_reg(REG_PANIC_AT, 32'd100);
                set_reg(REG_EASE_SHIFT, 32'd6);
            end
            3: begin
                // thresholds out of order, upper data bits junk, unused indices
                rx_idle_en = 1'b1;
                set_reg(REG_STALE_MS, 32'd500);
                set_reg(REG_AMBER_AT, 32'hFFFF_FF00 | 32'd90);
                set_reg(REG_RED_AT, 32'd30);
                set_reg(REG_PANIC_AT, 32'd60);
                set_reg(REG_EASE_SHIFT, 32'd1);
                for (int k = int'(REG_EASE_SHIFT) + 1; k < (1 << CFG_IDX_W); k++)
                    set_reg(CFG_IDX_W'(k), $urandom);
                hold_req = 1'b1;
            end
            4: begin
                tx_idle_en = 1'b1;
                a = $urandom_range(0, 100);
                r = $urandom_range(a, 100);
                set_reg(REG_STALE_MS, $urandom_range(0, 30000));
                set_reg(REG_AMBER_AT, a);
                set_reg(REG_RED_AT, r);
                set_reg(REG_PANIC_AT, $urandom_range(r, 100));
                set_reg(REG_EASE_SHIFT, $urandom_range(0, 6));
            end
            default: begin
                set_reg(REG_STALE_MS, STALE_MS_RST);
                set_reg(REG_AMBER_AT, AMBER_AT_RST);
                set_reg(REG_RED_AT, RED_AT_RST);
                set_reg(REG_PANIC_AT, PANIC_AT_RST);
                set_reg(REG_EASE_SHIFT, 32'd2);
            end
        endcase
    endtask

    initial begin
        int unsigned item_goal;
        board = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed: blanks and carriage return, stale edge across the wrap, odd bytes
        send_item(CMD_TICK, 8'h00, 32'h0000_0000);
        send_text("\0110 ,\013100\014\015\n", 32'hFFFF_FFF0);
        send_item(CMD_TICK, 8'hFF, 32'hFFFF_FFF0 + STALE_MS_RST);
        send_item(CMD_TICK, 8'hFF, 32'hFFFF_FFF0 + STALE_MS_RST + 32'd1);
        send_item(CMD_BYTE, 8'h00, 32'h0000_0000);
        send_item(CMD_BYTE, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_BYTE, CH_LF, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 8'h00, 32'hFFFF_FFFF);
        send_text("7,8\n", 32'hFFFF_FFFF);
        send_item(CMD_TICK, 8'h5A, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFFF;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                setup_phase(p);
            end
            item_goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < item_goal) random_burst();
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.expected_readouts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
